@@ src/rbv_pkg.sv @@
package rbv_pkg;

  // number format of the basis entries
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ENTRY_W   = 18;
  localparam int unsigned N_ENTRY   = 9;

  // tolerance register, unsigned Q0.16
  localparam int unsigned TOL_W        = 16;
  localparam int unsigned TOL_FRAC     = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W = N_ENTRY * ENTRY_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_IDX_TOL = 1'b0;

  // result codes
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_MIRRORED = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

endpackage

@@ src/rigid_basis_validator_top.sv @@
// throughput: one basis per cycle; stalls back up stage by stage, bubbles collapse
// datapath: 18x18 products, cofactor and dot sums, cofactor x row 0 products,
//   determinant sum, final compares and status register
// reset: rst_ni clears all stage valid bits and loads the tolerance with 66
module rigid_basis_validator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side: tdata = m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), zero pad
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rbv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // master side: tdata = status (2 bits), zero pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rbv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rbv_pkg::APB_AW-1:0]       paddr,
  input  logic [rbv_pkg::APB_DW-1:0]       pwdata,
  output logic [rbv_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import rbv_pkg::*;

  localparam int unsigned EW = ENTRY_W;
  localparam int unsigned PW = 2 * EW;       // entry product
  localparam int unsigned CW = PW + 1;       // cofactor
  localparam int unsigned TW = EW + CW;      // entry x cofactor
  localparam int unsigned DW = TW + 2;       // determinant
  localparam int unsigned SW = PW + 2;       // dot product sum
  localparam int unsigned DET_TOL_SH = 3 * FRAC_BITS - TOL_FRAC;
  localparam int unsigned DOT_TOL_SH = 2 * FRAC_BITS - TOL_FRAC;
  localparam logic [DW:0] DET_ONE =
    {{(DW - 3 * FRAC_BITS){1'b0}}, 1'b1, {(3 * FRAC_BITS){1'b0}}};
  localparam logic [SW:0] DOT_ONE =
    {{(SW - 2 * FRAC_BITS){1'b0}}, 1'b1, {(2 * FRAC_BITS){1'b0}}};

  // configuration register
  logic [TOL_W-1:0] tol_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_TOL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_wr) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_TOL) ? APB_DW'(tol_q) : '0;

  // stage handshake: a stage loads when it is empty or the next one moves
  logic [4:0] v_q;
  logic [4:0] rdy;

  assign rdy[4] = !v_q[4] || m_axis_tready;
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  // unpack entries
  logic signed [EW-1:0] m [N_ENTRY];

  always_comb begin
    for (int i = 0; i < N_ENTRY; i++) begin
      m[i] = $signed(s_axis_tdata[i*EW +: EW]);
    end
  end

  // stage 1: all 18x18 products
  logic signed [PW-1:0] cp_q [6];    // cofactor products
  logic signed [PW-1:0] sq_q [9];    // row self products, row*3+col
  logic signed [PW-1:0] xp_q [9];    // cross products: rows 0.1, 0.2, 1.2
  logic signed [EW-1:0] r0a_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      cp_q[0] <= m[4] * m[8];
      cp_q[1] <= m[5] * m[7];
      cp_q[2] <= m[3] * m[8];
      cp_q[3] <= m[5] * m[6];
      cp_q[4] <= m[3] * m[7];
      cp_q[5] <= m[4] * m[6];
      for (int i = 0; i < N_ENTRY; i++) begin
        sq_q[i] <= m[i] * m[i];
      end
      for (int c = 0; c < 3; c++) begin
        xp_q[c]     <= m[c] * m[3 + c];
        xp_q[3 + c] <= m[c] * m[6 + c];
        xp_q[6 + c] <= m[3 + c] * m[6 + c];
      end
      for (int c = 0; c < 3; c++) begin
        r0a_q[c] <= m[c];
      end
    end
  end

  // stage 2: cofactors and dot sums
  logic signed [CW-1:0] cof_q [3];
  logic signed [SW-1:0] self_q [3];
  logic signed [SW-1:0] cross_q [3];
  logic signed [EW-1:0] r0b_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      for (int k = 0; k < 3; k++) begin
        cof_q[k]   <= CW'(cp_q[2*k]) - CW'(cp_q[2*k + 1]);
        self_q[k]  <= SW'(sq_q[3*k]) + SW'(sq_q[3*k + 1]) + SW'(sq_q[3*k + 2]);
        cross_q[k] <= SW'(xp_q[3*k]) + SW'(xp_q[3*k + 1]) + SW'(xp_q[3*k + 2]);
        r0b_q[k]   <= r0a_q[k];
      end
    end
  end

  // dot checks against the tolerance scaled to the product format
  logic [SW:0]   self_dev  [3];
  logic [SW:0]   self_mag  [3];
  logic [SW-1:0] cross_mag [3];
  logic [SW:0]   dot_tol;
  logic          dot_bad;

  always_comb begin
    dot_tol = (SW + 1)'(tol_q) << DOT_TOL_SH;
    dot_bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      self_dev[k]  = {self_q[k][SW-1], self_q[k]} - DOT_ONE;
      self_mag[k]  = self_dev[k][SW] ? -self_dev[k] : self_dev[k];
      cross_mag[k] = cross_q[k][SW-1] ? -cross_q[k] : cross_q[k];
      if (self_mag[k] > dot_tol) dot_bad = 1'b1;
      if ({1'b0, cross_mag[k]} > dot_tol) dot_bad = 1'b1;
    end
  end

  // stage 3: row 0 entries times cofactors
  logic signed [TW-1:0] term_q [3];
  logic                 dot_bad3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      for (int k = 0; k < 3; k++) begin
        term_q[k] <= r0b_q[k] * cof_q[k];
      end
      dot_bad3_q <= dot_bad;
    end
  end

  // stage 4: determinant
  logic signed [DW-1:0] det_q;
  logic                 dot_bad4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      det_q      <= DW'(term_q[0]) - DW'(term_q[1]) + DW'(term_q[2]);
      dot_bad4_q <= dot_bad3_q;
    end
  end

  // determinant checks and status priority
  logic [DW:0] det_dev;
  logic [DW:0] det_mag;
  logic [DW:0] det_tol;
  status_e     status_d;
  status_e     status_q;

  always_comb begin
    det_dev = {det_q[DW-1], det_q} - DET_ONE;
    det_mag = det_dev[DW] ? -det_dev : det_dev;
    det_tol = (DW + 1)'(tol_q) << DET_TOL_SH;
    if (det_q[DW-1]) begin
      status_d = ST_MIRRORED;
    end else if ((det_mag > det_tol) || dot_bad4_q) begin
      status_d = ST_INVALID;
    end else begin
      status_d = ST_VALID;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = v_q[4];
  assign m_axis_tdata  = OUT_TDATA_W'(status_q);

  // a result never carries the unused status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("status code 3 on output");

  // an accepted transaction always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted transaction lost at stage 1");

  // a blocked full stage keeps its item
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && !rdy[4]) |=> v_q[3])
    else $error("stalled stage 4 dropped its item");

endmodule
